// File: hdl/kfq_pkg.sv
`timescale 1ns / 1ps
// Shared types, operation and status codes for the keyed FIFO queue.
// No dependencies; every other file of the block except kfq_ram imports this package.
package kfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int OP_W     = 3;
    localparam int DATA_W   = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    localparam logic [OP_W-1:0] OP_APPEND       = 3'd0;
    localparam logic [OP_W-1:0] OP_POP          = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE       = 3'd2;
    localparam logic [OP_W-1:0] OP_LOOKUP       = 3'd3;
    localparam logic [OP_W-1:0] OP_RESET_CURSOR = 3'd4;
    localparam logic [OP_W-1:0] OP_READ_NEXT    = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [1:0] {
        RES_OK,
        RES_HANDLE,
        RES_MISS,
        RES_FULL
    } res_kind_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_NEXT,
        RD_CURSOR
    } rd_sel_t;

    typedef struct packed {
        logic      take;
        logic      load;
        rd_sel_t   rd_sel;
        logic      wr_tail;
        logic      wr_shift;
        logic      idx_inc;
        logic      count_inc;
        logic      count_dec;
        logic      cursor_clear;
        logic      cursor_inc;
        logic      cursor_adj;
        logic      res_set;
        res_kind_t res_kind;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        logic            in_valid;
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            scan_end;
        logic            shift_end;
        logic            cursor_null;
        logic            key_hit;
        logic            out_free;
    } stat_t;

endpackage

// File: hdl/kfq_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the keyed FIFO queue request and result.
// Depends on kfq_pkg for field widths.
interface kfq_in_if;
    import kfq_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] entry_handle;
    logic [DATA_W-1:0] entry_key;

    modport source (output valid, op, entry_handle, entry_key, input ready);
    modport sink   (input valid, op, entry_handle, entry_key, output ready);
endinterface

interface kfq_out_if;
    import kfq_pkg::*;

    logic                valid;
    logic                ready;
    logic                valid_out;
    logic [DATA_W-1:0]   handle_out;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;

    modport source (output valid, valid_out, handle_out, status, occupancy, input ready);
    modport sink   (input valid, valid_out, handle_out, status, occupancy, output ready);
endinterface

// File: hdl/kfq_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kfq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/kfq_dp.sv
`timescale 1ns / 1ps
// Datapath of the keyed FIFO queue: entry RAM, count, cursor, scan index and result register.
// Depends on kfq_pkg, kfq_if and kfq_ram; driven by commands from kfq_ctrl.
module kfq_dp #(
    parameter int QUEUE_DEPTH = kfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    kfq_in_if.sink         in_ch,
    kfq_out_if.source      out_ch,
    input  kfq_pkg::cmd_t  cmd,
    output kfq_pkg::stat_t stat
);
    import kfq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int WW = 2 * DATA_W;

    logic [OP_W-1:0]     op_reg;
    logic [DATA_W-1:0]   hnd_reg;
    logic [DATA_W-1:0]   key_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       cursor_reg, cursor_next;
    logic [CW-1:0]       idx_reg;
    logic [CW-1:0]       idx_plus1;
    logic                res_valid_reg;
    logic [DATA_W-1:0]   res_handle_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                out_valid_reg;
    logic                out_vout_reg;
    logic [DATA_W-1:0]   out_handle_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic [OCC_W-1:0]    out_occ_reg;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WW-1:0]       ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [WW-1:0]       ram_q;

    assign idx_plus1 = idx_reg + CW'(1);

    kfq_ram #(
        .WIDTH (WW),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign ram_we    = cmd.wr_tail | cmd.wr_shift;
    assign ram_waddr = cmd.wr_tail ? count_reg[AW-1:0] : idx_reg[AW-1:0];
    assign ram_wdata = cmd.wr_tail ? {hnd_reg, key_reg} : ram_q;

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:    ram_raddr = idx_reg[AW-1:0];
            RD_NEXT:   ram_raddr = idx_plus1[AW-1:0];
            RD_CURSOR: ram_raddr = cursor_reg[AW-1:0];
            default:   ram_raddr = idx_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    // A null cursor stays past the end when the queue grows.
    always_comb
    begin
        cursor_next = cursor_reg;
        if (cmd.cursor_clear)
        begin
            cursor_next = '0;
        end
        else if (cmd.cursor_inc)
        begin
            cursor_next = cursor_reg + CW'(1);
        end
        else if (cmd.count_inc && (cursor_reg >= count_reg))
        begin
            cursor_next = count_reg + CW'(1);
        end
        else if (cmd.cursor_adj && (cursor_reg > idx_reg))
        begin
            cursor_next = cursor_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            cursor_reg <= cursor_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= in_ch.op;
            hnd_reg <= in_ch.entry_handle;
            key_reg <= in_ch.entry_key;
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_plus1;
        end

        if (cmd.res_set)
        begin
            case (cmd.res_kind)
                RES_HANDLE:
                begin
                    res_valid_reg  <= 1'b1;
                    res_handle_reg <= ram_q[WW-1:DATA_W];
                    res_status_reg <= ST_OK;
                end
                RES_MISS:
                begin
                    res_valid_reg  <= 1'b0;
                    res_handle_reg <= '0;
                    res_status_reg <= ST_MISS;
                end
                RES_FULL:
                begin
                    res_valid_reg  <= 1'b0;
                    res_handle_reg <= '0;
                    res_status_reg <= ST_FULL;
                end
                default:
                begin
                    res_valid_reg  <= 1'b0;
                    res_handle_reg <= '0;
                    res_status_reg <= ST_OK;
                end
            endcase
        end

        if (cmd.out_load)
        begin
            out_vout_reg   <= res_valid_reg;
            out_handle_reg <= res_handle_reg;
            out_status_reg <= res_status_reg;
            out_occ_reg    <= OCC_W'(count_reg);
        end
    end

    assign in_ch.ready       = cmd.take;
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.valid_out  = out_vout_reg;
    assign out_ch.handle_out = out_handle_reg;
    assign out_ch.status     = out_status_reg;
    assign out_ch.occupancy  = out_occ_reg;

    assign stat.in_valid    = in_ch.valid;
    assign stat.op          = op_reg;
    assign stat.full        = (count_reg == CW'(QUEUE_DEPTH));
    assign stat.empty       = (count_reg == '0);
    assign stat.scan_end    = (idx_reg >= count_reg);
    assign stat.shift_end   = (idx_plus1 >= count_reg);
    assign stat.cursor_null = (cursor_reg >= count_reg);
    assign stat.key_hit     = (ram_q[DATA_W-1:0] == key_reg);
    assign stat.out_free    = !out_valid_reg || out_ch.ready;

    assert property (@(posedge clk) disable iff (!rst_n) cursor_reg <= count_reg)
        else $error("cursor beyond end of queue");

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count exceeds depth");

    assert property (@(posedge clk) disable iff (!rst_n) cmd.wr_shift |-> idx_plus1 < count_reg)
        else $error("shift write outside occupied slots");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.count_inc |=> count_reg == $past(count_reg) + CW'(1))
        else $error("append did not grow the queue by one");

endmodule

// File: hdl/kfq_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the keyed FIFO queue: sequences decode, scan, shift and result.
// Depends on kfq_pkg; issues commands to kfq_dp and reads its status.
module kfq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  kfq_pkg::stat_t stat,
    output kfq_pkg::cmd_t  cmd
);
    import kfq_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DECODE   = 3'd1;
    localparam logic [2:0] S_POP_DAT  = 3'd2;
    localparam logic [2:0] S_CHECK    = 3'd3;
    localparam logic [2:0] S_SHIFT    = 3'd4;
    localparam logic [2:0] S_SHIFT_WR = 3'd5;
    localparam logic [2:0] S_RN_DAT   = 3'd6;
    localparam logic [2:0] S_DONE     = 3'd7;

    logic [2:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_APPEND:
                    begin
                        cmd.res_set = 1'b1;
                        if (stat.full)
                        begin
                            cmd.res_kind = RES_FULL;
                        end
                        else
                        begin
                            cmd.res_kind  = RES_OK;
                            cmd.wr_tail   = 1'b1;
                            cmd.count_inc = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    OP_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_kind = RES_MISS;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_IDX;
                            state_next = S_POP_DAT;
                        end
                    end
                    OP_REMOVE, OP_LOOKUP:
                    begin
                        if (stat.scan_end)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_kind = RES_MISS;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_IDX;
                            state_next = S_CHECK;
                        end
                    end
                    OP_RESET_CURSOR:
                    begin
                        cmd.cursor_clear = 1'b1;
                        cmd.res_set      = 1'b1;
                        cmd.res_kind     = RES_OK;
                        state_next       = S_DONE;
                    end
                    OP_READ_NEXT:
                    begin
                        if (stat.cursor_null)
                        begin
                            cmd.res_set  = 1'b1;
                            cmd.res_kind = RES_MISS;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_CURSOR;
                            state_next = S_RN_DAT;
                        end
                    end
                    default:
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_kind = RES_OK;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_POP_DAT:
            begin
                cmd.res_set    = 1'b1;
                cmd.res_kind   = RES_HANDLE;
                cmd.cursor_adj = 1'b1;
                state_next     = S_SHIFT;
            end
            S_CHECK:
            begin
                if (stat.key_hit)
                begin
                    cmd.res_set = 1'b1;
                    if (stat.op == OP_LOOKUP)
                    begin
                        cmd.res_kind = RES_HANDLE;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.res_kind   = RES_OK;
                        cmd.cursor_adj = 1'b1;
                        state_next     = S_SHIFT;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_end)
                begin
                    cmd.count_dec = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_sel = RD_NEXT;
                    state_next = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = S_SHIFT;
            end
            S_RN_DAT:
            begin
                cmd.res_set    = 1'b1;
                cmd.res_kind   = RES_HANDLE;
                cmd.cursor_inc = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                // hold the result until the output register frees up
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/keyed_fifo_queue.sv
`timescale 1ns / 1ps
// Keyed FIFO queue: ordered task queue with append, pop, remove and lookup by key,
// and a read cursor. Depends on kfq_pkg, kfq_if, kfq_ctrl and kfq_dp.
//
// Entries sit packed in one RAM, head at slot 0. Every request gives exactly one
// transfer on the result channel. Append, cursor reset, unused codes, pop of an empty
// queue and read-next on a null cursor go straight from decode to the result; a
// read-next that returns a handle first reads the RAM at the cursor. Lookup and
// remove scan the RAM slot by slot from the head, each slot read and then checked
// against the key, until a match or the end of the queue. Pop and remove then close
// the gap slot by slot, each entry behind the taken one read and written one slot
// nearer the head. A finished result waits while the result channel stalls an
// earlier result. A new request is taken once the previous one has reached the
// output register, even while that result still waits to be taken. The RAM needs
// no clearing after reset.
module keyed_fifo_queue #(
    parameter int QUEUE_DEPTH = kfq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    kfq_in_if.sink    in_ch,
    kfq_out_if.source out_ch
);
    import kfq_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    kfq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    kfq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule
